// ===== rtl/jhpd_pkg.sv =====
// ----------------------------------------------------------------------------
// jhpd_pkg - shared types and constants of the joint hold PD controller
// Command, status and result-kind codes, stream widths, and the control and
// operand bundles that drive the shared multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jhpd_pkg;

  // stream and field widths
  localparam int Q_W         = 32;
  localparam int LIM_W       = 23;
  localparam int IN_TDATA_W  = 192;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 17;
  localparam int ALPHA_W     = 17;
  localparam int ARMS_CFG_W  = 2;

  // multiplier operand and product widths
  localparam int OPND_W = 33;
  localparam int PROD_W = 66;

  // half an LSB of Q16.16, added before the floor shift
  localparam int RND_HALF = 32768;

  // one in Q1.16
  localparam logic [ALPHA_W-1:0] ONE_Q16 = 17'h10000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ARMS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 1'b1;

  // item commands
  localparam logic [1:0] CMD_RUN     = 2'd0;
  localparam logic [1:0] CMD_CAPTURE = 2'd1;
  localparam logic [1:0] CMD_LOAD    = 2'd2;
  localparam logic [1:0] CMD_DEACT   = 2'd3;

  // result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FAULT    = 2'd1;
  localparam logic [1:0] STATUS_INACTIVE = 2'd2;

  // kinds of result burst
  localparam logic [1:0] EMIT_COMMIT = 2'd0;
  localparam logic [1:0] EMIT_ZERO   = 2'd1;
  localparam logic [1:0] EMIT_STATUS = 2'd2;

  // multiplier operand selections
  localparam logic [1:0] MUL_W0_FV  = 2'd0;
  localparam logic [1:0] MUL_A_VEL  = 2'd1;
  localparam logic [1:0] MUL_K_DIFF = 2'd2;
  localparam logic [1:0] MUL_D_F    = 2'd3;

  typedef struct packed {
    logic       en;
    logic [1:0] sel;
  } mul_ctl_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] w_keep;
    logic [ALPHA_W-1:0] w_new;
    logic signed [Q_W-1:0] fv;
    logic signed [Q_W-1:0] vel;
    logic [Q_W-1:0]        k;
    logic [Q_W-1:0]        d;
    logic signed [Q_W-1:0] hold;
    logic signed [Q_W-1:0] pos;
    logic signed [Q_W-1:0] f;
  } mul_opnd_t;

endpackage

// ===== rtl/jhpd_mul.sv =====
// ----------------------------------------------------------------------------
// jhpd_mul - shared signed multiplier of the joint hold PD controller
// Selects one operand pair per cycle (filter weights, stiffness or damping
// terms) and registers the full-precision signed product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jhpd_mul (
  input  logic                                    clk,
  input  jhpd_pkg::mul_ctl_t                      ctl,
  input  jhpd_pkg::mul_opnd_t                     opnd,
  output logic signed [jhpd_pkg::PROD_W-1:0]      prod_r
);

  logic signed [jhpd_pkg::OPND_W-1:0] op_a;
  logic signed [jhpd_pkg::OPND_W-1:0] op_b;
  logic signed [jhpd_pkg::PROD_W-1:0] prod_nxt;

  // pick the operand pair; gains and weights are non-negative
  always_comb begin
    case (ctl.sel)
      jhpd_pkg::MUL_W0_FV: begin
        op_a = {16'd0, opnd.w_keep};
        op_b = {opnd.fv[31], opnd.fv};
      end
      jhpd_pkg::MUL_A_VEL: begin
        op_a = {16'd0, opnd.w_new};
        op_b = {opnd.vel[31], opnd.vel};
      end
      jhpd_pkg::MUL_K_DIFF: begin
        op_a = {1'b0, opnd.k};
        op_b = {opnd.hold[31], opnd.hold} - {opnd.pos[31], opnd.pos};
      end
      jhpd_pkg::MUL_D_F: begin
        op_a = {1'b0, opnd.d};
        op_b = {opnd.f[31], opnd.f};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_nxt = op_a * op_b;

  // hold the product for the accumulate step
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

// ===== rtl/joint_hold_pd_controller.sv =====
// ----------------------------------------------------------------------------
// joint_hold_pd_controller - PD joint position hold with velocity filter
// A run item passes latch, dispatch, then six steps around the one shared
// 33x33 multiplier before ready returns; capture, load and deactivate
// items pass latch and dispatch only. A closing item streams up to
// ARMS*JOINTS result words at one per cycle while out_tready is high.
// Synchronous active-low reset clears control, restores configuration defaults
// and marks the gain tables unloaded; hold and velocity stores start unset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module joint_hold_pd_controller #(
  parameter int JOINTS = 7,
  parameter int ARMS   = 2
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // arm_sel, joint_sel, position, velocity, coriolis, k_gain, d_gain,
  // effort_limit, zero fill
  input  logic [jhpd_pkg::IN_TDATA_W-1:0]      in_tdata,
  // cmd, sample_ok
  input  logic [jhpd_pkg::IN_TUSER_W-1:0]      in_tuser,
  input  logic                                 in_tlast,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // out_arm, out_joint, effort, zero fill
  output logic [jhpd_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // write_valid, status
  output logic [jhpd_pkg::OUT_TUSER_W-1:0]     out_tuser,
  output logic                                 out_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_we,
  input  logic [jhpd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [jhpd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int SLOTS  = ARMS * JOINTS;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int JNT_W  = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int ARM_W  = (ARMS > 1) ? $clog2(ARMS) : 1;
  localparam int ARM_CW = $clog2(ARMS + 1);

  // sequencer states
  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_DISPATCH = 2'd1;
  localparam logic [1:0] ST_CALC     = 2'd2;
  localparam logic [1:0] ST_EMIT     = 2'd3;

  // calculation steps
  localparam logic [2:0] STEP_FILT_A   = 3'd0;
  localparam logic [2:0] STEP_FILT_B   = 3'd1;
  localparam logic [2:0] STEP_FILT_SUM = 3'd2;
  localparam logic [2:0] STEP_EFF_K    = 3'd3;
  localparam logic [2:0] STEP_EFF_D    = 3'd4;
  localparam logic [2:0] STEP_CHECK    = 3'd5;

  // configuration
  logic [jhpd_pkg::ARMS_CFG_W-1:0] arms_cfg_r;
  logic [jhpd_pkg::ALPHA_W-1:0]    alpha_cfg_r;

  // latched item
  logic [1:0]                  cmd_r;
  logic                        arm_r;
  logic [2:0]                  joint_r;
  logic signed [31:0]          pos_r;
  logic signed [31:0]          vel_r;
  logic signed [31:0]          cor_r;
  logic                        ok_r;
  logic                        last_r;
  logic [31:0]                 kg_r;
  logic [31:0]                 dg_r;
  logic [jhpd_pkg::LIM_W-1:0]  lim_r;

  // per-joint stores
  logic [31:0]                 hold_r     [SLOTS];
  logic [31:0]                 fv_r       [SLOTS];
  logic [31:0]                 pend_vel_r [SLOTS];
  logic [31:0]                 pend_eff_r [SLOTS];
  logic [31:0]                 stiff_r    [SLOTS];
  logic [31:0]                 damp_r     [SLOTS];
  logic [jhpd_pkg::LIM_W-1:0]  lim_tab_r  [SLOTS];
  logic [SLOTS-1:0]            gain_vld_r;

  // control state
  logic [1:0] state_r, state_nxt;
  logic [2:0] step_r, step_nxt;
  logic       active_r, active_nxt;
  logic       zero_needed_r, zero_needed_nxt;
  logic       faulted_r, faulted_nxt;

  // result burst
  logic [SLOT_W-1:0] em_slot_r, em_slot_nxt;
  logic [SLOT_W-1:0] em_end_r, em_end_nxt;
  logic [ARM_W-1:0]  em_arm_r, em_arm_nxt;
  logic [JNT_W-1:0]  em_joint_r, em_joint_nxt;
  logic [1:0]        em_kind_r, em_kind_nxt;
  logic [1:0]        em_status_r, em_status_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic        out_arm_r, out_arm_nxt;
  logic [2:0]  out_joint_r, out_joint_nxt;
  logic [31:0] out_eff_r, out_eff_nxt;
  logic        out_wv_r, out_wv_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic        out_last_r, out_last_nxt;

  // datapath
  logic signed [48:0] acc_r, acc_nxt;
  logic signed [31:0] f_r, f_nxt;
  logic signed [51:0] e_r, e_nxt;
  logic signed [jhpd_pkg::PROD_W-1:0] prod_r;
  logic signed [jhpd_pkg::PROD_W-1:0] prod_rnd;
  logic signed [49:0] filt_sum;
  logic signed [51:0] e_mag;

  // derived and write controls
  logic [ARM_CW-1:0]          arms_now;
  logic [SLOT_W-1:0]          n_last;
  logic [SLOT_W-1:0]          idx;
  logic                       in_use;
  logic                       load_ok;
  logic [jhpd_pkg::ALPHA_W-1:0] alpha_eff;
  logic [31:0]                k_eff;
  logic [31:0]                d_eff;
  logic [jhpd_pkg::LIM_W-1:0] lim_eff;
  logic                       fault_set;
  logic                       faulted_now;
  logic                       do_close;
  logic                       tab_we;
  logic                       hold_we;
  logic                       pend_we;
  logic                       fv_we;
  logic [SLOT_W-1:0]          fv_wa;
  logic [31:0]                fv_wd;

  jhpd_pkg::mul_ctl_t  mul_ctl;
  jhpd_pkg::mul_opnd_t mul_opnd;

  // clamp the arm count to one..ARMS
  always_comb begin
    if (arms_cfg_r == '0) begin
      arms_now = ARM_CW'(1);
    end else if (32'(arms_cfg_r) > ARMS) begin
      arms_now = ARM_CW'(ARMS);
    end else begin
      arms_now = ARM_CW'(arms_cfg_r);
    end
  end

  assign n_last    = SLOT_W'(32'(arms_now) * JOINTS - 1);
  assign idx       = SLOT_W'(32'(arm_r) * JOINTS + 32'(joint_r));
  assign in_use    = (32'(arm_r) < 32'(arms_now)) && (32'(joint_r) < JOINTS);
  assign load_ok   = (32'(arm_r) < ARMS) && (32'(joint_r) < JOINTS);
  assign alpha_eff = (alpha_cfg_r > jhpd_pkg::ONE_Q16) ? jhpd_pkg::ONE_Q16 : alpha_cfg_r;

  // unloaded gain entries read as zero
  assign k_eff   = gain_vld_r[idx] ? stiff_r[idx] : '0;
  assign d_eff   = gain_vld_r[idx] ? damp_r[idx] : '0;
  assign lim_eff = gain_vld_r[idx] ? lim_tab_r[idx] : '0;

  // shared multiplier
  assign mul_opnd.w_keep = jhpd_pkg::ONE_Q16 - alpha_eff;
  assign mul_opnd.w_new  = alpha_eff;
  assign mul_opnd.fv     = fv_r[idx];
  assign mul_opnd.vel    = vel_r;
  assign mul_opnd.k      = k_eff;
  assign mul_opnd.d      = d_eff;
  assign mul_opnd.hold   = hold_r[idx];
  assign mul_opnd.pos    = pos_r;
  assign mul_opnd.f      = f_r;

  always_comb begin
    mul_ctl.en = (state_r == ST_CALC) && (step_r <= STEP_EFF_K);
    case (step_r)
      STEP_FILT_A:   mul_ctl.sel = jhpd_pkg::MUL_W0_FV;
      STEP_FILT_B:   mul_ctl.sel = jhpd_pkg::MUL_A_VEL;
      STEP_FILT_SUM: mul_ctl.sel = jhpd_pkg::MUL_K_DIFF;
      STEP_EFF_K:    mul_ctl.sel = jhpd_pkg::MUL_D_F;
      default:       mul_ctl.sel = jhpd_pkg::MUL_W0_FV;
    endcase
  end

  jhpd_mul u_mul (
    .clk    (clk),
    .ctl    (mul_ctl),
    .opnd   (mul_opnd),
    .prod_r (prod_r)
  );

  // round-to-nearest helpers: floor((x + half) / 65536) is a bit slice
  assign prod_rnd = prod_r + jhpd_pkg::PROD_W'(jhpd_pkg::RND_HALF);
  assign filt_sum = {acc_r[48], acc_r} + {prod_r[48], prod_r[48:0]}
                  + 50'(jhpd_pkg::RND_HALF);
  assign e_mag    = e_r[51] ? -e_r : e_r;

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    step_nxt        = step_r;
    active_nxt      = active_r;
    zero_needed_nxt = zero_needed_r;
    faulted_nxt     = faulted_r;
    em_slot_nxt     = em_slot_r;
    em_end_nxt      = em_end_r;
    em_arm_nxt      = em_arm_r;
    em_joint_nxt    = em_joint_r;
    em_kind_nxt     = em_kind_r;
    em_status_nxt   = em_status_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_arm_nxt     = out_arm_r;
    out_joint_nxt   = out_joint_r;
    out_eff_nxt     = out_eff_r;
    out_wv_nxt      = out_wv_r;
    out_status_nxt  = out_status_r;
    out_last_nxt    = out_last_r;
    acc_nxt         = acc_r;
    f_nxt           = f_r;
    e_nxt           = e_r;
    fault_set       = 1'b0;
    do_close        = 1'b0;
    tab_we          = 1'b0;
    hold_we         = 1'b0;
    pend_we         = 1'b0;
    fv_we           = 1'b0;
    fv_wa           = idx;
    fv_wd           = vel_r;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        state_nxt = ST_IDLE;
        case (cmd_r)
          jhpd_pkg::CMD_LOAD: begin
            tab_we = load_ok;
          end
          jhpd_pkg::CMD_DEACT: begin
            active_nxt = 1'b0;
          end
          jhpd_pkg::CMD_CAPTURE: begin
            // latch hold position and seed the filter
            hold_we   = in_use && ok_r;
            fv_we     = in_use && ok_r;
            fault_set = !(in_use && ok_r);
            do_close  = last_r;
          end
          default: begin
            if (active_r && in_use && ok_r) begin
              state_nxt = ST_CALC;
              step_nxt  = STEP_FILT_A;
            end else begin
              fault_set = active_r;
              do_close  = last_r;
            end
          end
        endcase
      end

      ST_CALC: begin
        step_nxt = step_r + 3'd1;
        case (step_r)
          STEP_FILT_B: begin
            acc_nxt = prod_r[48:0];
          end
          STEP_FILT_SUM: begin
            f_nxt = filt_sum[47:16];
          end
          STEP_EFF_K: begin
            e_nxt = {{2{prod_rnd[65]}}, prod_rnd[65:16]};
          end
          STEP_EFF_D: begin
            e_nxt = e_r - {{2{prod_rnd[65]}}, prod_rnd[65:16]}
                  + {{20{cor_r[31]}}, cor_r};
          end
          STEP_CHECK: begin
            // fault the cycle on an effort beyond the joint limit
            if (e_mag > {29'd0, lim_eff}) begin
              fault_set = 1'b1;
            end else begin
              pend_we = 1'b1;
            end
            do_close  = last_r;
            state_nxt = ST_IDLE;
          end
          default: begin
          end
        endcase
      end

      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_arm_nxt    = 1'(em_arm_r);
          out_joint_nxt  = 3'(em_joint_r);
          out_eff_nxt    = (em_kind_r == jhpd_pkg::EMIT_COMMIT) ? pend_eff_r[em_slot_r] : '0;
          out_wv_nxt     = (em_kind_r != jhpd_pkg::EMIT_STATUS);
          out_status_nxt = em_status_r;
          out_last_nxt   = (em_slot_r == em_end_r);
          // commit the filtered velocity as its effort goes out
          fv_we = (em_kind_r == jhpd_pkg::EMIT_COMMIT);
          fv_wa = em_slot_r;
          fv_wd = pend_vel_r[em_slot_r];
          if (em_slot_r == em_end_r) begin
            state_nxt = ST_IDLE;
          end else begin
            em_slot_nxt = em_slot_r + SLOT_W'(1);
            if (32'(em_joint_r) == JOINTS - 1) begin
              em_joint_nxt = '0;
              em_arm_nxt   = em_arm_r + ARM_W'(1);
            end else begin
              em_joint_nxt = em_joint_r + JNT_W'(1);
            end
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    faulted_now = faulted_r || fault_set;
    if (fault_set) begin
      faulted_nxt = 1'b1;
    end

    // close the control cycle and set up the result burst
    if (do_close) begin
      state_nxt    = ST_EMIT;
      em_slot_nxt  = '0;
      em_arm_nxt   = '0;
      em_joint_nxt = '0;
      em_end_nxt   = n_last;
      if (cmd_r == jhpd_pkg::CMD_CAPTURE) begin
        em_kind_nxt     = jhpd_pkg::EMIT_ZERO;
        em_status_nxt   = faulted_now ? jhpd_pkg::STATUS_FAULT : jhpd_pkg::STATUS_OK;
        active_nxt      = !faulted_now;
        zero_needed_nxt = 1'b0;
        faulted_nxt     = 1'b0;
      end else if (active_r && !faulted_now) begin
        em_kind_nxt     = jhpd_pkg::EMIT_COMMIT;
        em_status_nxt   = jhpd_pkg::STATUS_OK;
        zero_needed_nxt = 1'b1;
      end else begin
        em_status_nxt = active_r ? jhpd_pkg::STATUS_FAULT : jhpd_pkg::STATUS_INACTIVE;
        faulted_nxt   = 1'b0;
        if (zero_needed_r) begin
          em_kind_nxt     = jhpd_pkg::EMIT_ZERO;
          zero_needed_nxt = 1'b0;
        end else begin
          em_kind_nxt = jhpd_pkg::EMIT_STATUS;
          em_end_nxt  = '0;
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      step_r        <= STEP_FILT_A;
      active_r      <= 1'b0;
      zero_needed_r <= 1'b0;
      faulted_r     <= 1'b0;
      em_slot_r     <= '0;
      em_end_r      <= '0;
      em_arm_r      <= '0;
      em_joint_r    <= '0;
      em_kind_r     <= jhpd_pkg::EMIT_STATUS;
      em_status_r   <= jhpd_pkg::STATUS_OK;
      out_valid_r   <= 1'b0;
      gain_vld_r    <= '0;
      arms_cfg_r    <= 2'd2;
      alpha_cfg_r   <= 17'd6554;
    end else begin
      state_r       <= state_nxt;
      step_r        <= step_nxt;
      active_r      <= active_nxt;
      zero_needed_r <= zero_needed_nxt;
      faulted_r     <= faulted_nxt;
      em_slot_r     <= em_slot_nxt;
      em_end_r      <= em_end_nxt;
      em_arm_r      <= em_arm_nxt;
      em_joint_r    <= em_joint_nxt;
      em_kind_r     <= em_kind_nxt;
      em_status_r   <= em_status_nxt;
      out_valid_r   <= out_valid_nxt;
      if (tab_we) begin
        gain_vld_r[idx] <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          jhpd_pkg::REG_ARMS:  arms_cfg_r  <= cfg_wdata[jhpd_pkg::ARMS_CFG_W-1:0];
          jhpd_pkg::REG_ALPHA: alpha_cfg_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid) begin
      cmd_r   <= in_tuser[1:0];
      ok_r    <= in_tuser[2];
      last_r  <= in_tlast;
      arm_r   <= in_tdata[0];
      joint_r <= in_tdata[3:1];
      pos_r   <= in_tdata[35:4];
      vel_r   <= in_tdata[67:36];
      cor_r   <= in_tdata[99:68];
      kg_r    <= in_tdata[131:100];
      dg_r    <= in_tdata[163:132];
      lim_r   <= in_tdata[186:164];
    end
    out_arm_r    <= out_arm_nxt;
    out_joint_r  <= out_joint_nxt;
    out_eff_r    <= out_eff_nxt;
    out_wv_r     <= out_wv_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
    acc_r        <= acc_nxt;
    f_r          <= f_nxt;
    e_r          <= e_nxt;
  end

  // per-joint stores
  always_ff @(posedge clk) begin
    if (tab_we) begin
      stiff_r[idx]   <= kg_r;
      damp_r[idx]    <= dg_r;
      lim_tab_r[idx] <= lim_r;
    end
    if (hold_we) begin
      hold_r[idx] <= pos_r;
    end
    if (fv_we) begin
      fv_r[fv_wa] <= fv_wd;
    end
    if (pend_we) begin
      pend_vel_r[idx] <= f_r;
      pend_eff_r[idx] <= e_r[31:0];
    end
  end

  // ports
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_eff_r, out_joint_r, out_arm_r};
  assign out_tuser  = {out_status_r, out_wv_r};
  assign out_tlast  = out_last_r;

  // a status-only word always closes its burst
  a_status_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> out_tlast)
    else $error("status-only word without tlast");

  // fault and inactive words carry no effort
  a_fault_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[2:1] != jhpd_pkg::STATUS_OK) |-> (out_tdata[35:4] == '0))
    else $error("non-zero effort on a fault or inactive word");

  // calculation never runs past its check step
  a_step_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC) |-> (step_r <= STEP_CHECK))
    else $error("calculation step out of range");

  // one item at a time: ready drops after an accepted word
  a_one_item : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("ready held after an accepted word");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - self-checking bench for joint_hold_pd_controller
// Drives capture, run, load and deactivate words into the input stream and
// predicts every result word: PD efforts, zero bursts and status words.
// A short directed run covers the corner cases. Random control cycles
// follow under several register settings, with random idling on both
// streams and a watchdog on handshake progress.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

localparam int JOINTS = 7;
localparam int ARMS   = 2;
localparam int SLOTS  = ARMS * JOINTS;

// one input word: command, sample flags and payload fields of one item
typedef struct packed {
  bit [1:0]  cmd;
  bit        arm;
  bit [2:0]  joint;
  bit [31:0] pos;
  bit [31:0] vel;
  bit [31:0] cor;
  bit        ok;
  bit        last;
  bit [31:0] k;
  bit [31:0] d;
  bit [22:0] lim;
} joint_word_t;

// one result word
typedef struct packed {
  bit        arm;
  bit [2:0]  joint;
  bit [31:0] effort;
  bit        wv;
  bit [1:0]  st;
  bit        last;
} effort_word_t;

// Tracks the controller state and the efforts still due from the block.
class effort_predictor;
  bit [1:0]  arms_cfg  = 2'd2;
  bit [16:0] alpha_cfg = 17'd6554;
  longint    hold[SLOTS];
  longint    filt[SLOTS];
  longint    pvel[SLOTS];
  longint    peff[SLOTS];
  bit        hold_set[SLOTS];
  bit        pend_set[SLOTS];
  bit [31:0] kt[SLOTS];
  bit [31:0] dt[SLOTS];
  bit [22:0] lt[SLOTS];
  bit        active;
  bit        zero_req;
  bit        faulted;
  effort_word_t due_efforts[$];
  int        errors;

  function int arms_now();
    if (arms_cfg < 1) return 1;
    if (arms_cfg > ARMS) return ARMS;
    return int'(arms_cfg);
  endfunction

  // floor((s + half) / 2^16)
  function longint rnd16(longint s);
    return (s + 64'sd32768) >>> 16;
  endfunction

  function longint mulq(bit [31:0] g, longint x);
    longint hi;
    longint lo;
    hi = longint'(g[31:16]);
    lo = longint'(g[15:0]);
    return hi * x + rnd16(lo * x);
  endfunction

  // filtered velocity and effort of one run word
  function void calc(int idx, joint_word_t w, output longint f, output longint e);
    longint a;
    a = (alpha_cfg > 17'd65536) ? 64'sd65536 : longint'(alpha_cfg);
    f = rnd16((64'sd65536 - a) * filt[idx] + a * longint'($signed(w.vel)));
    e = mulq(kt[idx], hold[idx] - longint'($signed(w.pos))) - mulq(dt[idx], f)
        + longint'($signed(w.cor));
  endfunction

  function void queue_result(bit arm, bit [2:0] joint, bit [31:0] e, bit wv,
                             bit [1:0] st, bit last);
    effort_word_t r;
    r.arm = arm;
    r.joint = joint;
    r.effort = e;
    r.wv = wv;
    r.st = st;
    r.last = last;
    due_efforts = {due_efforts, r};
  endfunction

  function void queue_zero_burst(bit [1:0] st);
    int n;
    n = arms_now() * JOINTS;
    for (int s = 0; s < n; s++)
      queue_result(1'(s / JOINTS), 3'(s % JOINTS), 32'd0, 1'b1, st, s == n - 1);
  endfunction

  // True when the word would read a store entry that was never written.
  function bit reads_unset(joint_word_t w);
    bit in_use;
    int idx;
    int n;
    int will_set;
    bit fault;
    longint f;
    longint e;
    longint mag;
    if (w.cmd != jhpd_pkg::CMD_RUN || !active) return 1'b0;
    in_use = (w.arm < arms_now()) && (w.joint < JOINTS);
    idx = in_use ? w.arm * JOINTS + w.joint : 0;
    fault = faulted;
    will_set = -1;
    if (in_use && w.ok) begin
      if (!hold_set[idx]) return 1'b1;
      calc(idx, w, f, e);
      mag = (e < 0) ? -e : e;
      if (mag > longint'(lt[idx])) fault = 1'b1;
      else will_set = idx;
    end else begin
      fault = 1'b1;
    end
    if (!w.last || fault) return 1'b0;
    n = arms_now() * JOINTS;
    for (int s = 0; s < n; s++)
      if (!pend_set[s] && s != will_set) return 1'b1;
    return 1'b0;
  endfunction

  // Advance the state by one accepted word and queue the results it causes.
  function void note_word(joint_word_t w);
    bit in_use;
    int idx;
    int n;
    longint f;
    longint e;
    longint mag;
    bit [1:0] st;
    in_use = (w.arm < arms_now()) && (w.joint < JOINTS);
    idx = in_use ? w.arm * JOINTS + w.joint : 0;
    case (w.cmd)
      jhpd_pkg::CMD_LOAD: begin
        if (w.joint < JOINTS) begin
          kt[w.arm * JOINTS + w.joint] = w.k;
          dt[w.arm * JOINTS + w.joint] = w.d;
          lt[w.arm * JOINTS + w.joint] = w.lim;
        end
      end
      jhpd_pkg::CMD_DEACT: begin
        active = 1'b0;
      end
      jhpd_pkg::CMD_CAPTURE: begin
        if (in_use && w.ok) begin
          hold[idx] = longint'($signed(w.pos));
          filt[idx] = longint'($signed(w.vel));
          hold_set[idx] = 1'b1;
        end else begin
          faulted = 1'b1;
        end
        if (w.last) begin
          st = faulted ? jhpd_pkg::STATUS_FAULT : jhpd_pkg::STATUS_OK;
          active = !faulted;
          queue_zero_burst(st);
          zero_req = 1'b0;
          faulted = 1'b0;
        end
      end
      default: begin
        if (active) begin
          if (in_use && w.ok) begin
            calc(idx, w, f, e);
            mag = (e < 0) ? -e : e;
            if (mag > longint'(lt[idx])) begin
              faulted = 1'b1;
            end else begin
              pvel[idx] = f;
              peff[idx] = e;
              pend_set[idx] = 1'b1;
            end
          end else begin
            faulted = 1'b1;
          end
        end
        if (w.last) begin
          if (active && !faulted) begin
            // commit filtered velocities and release every effort
            n = arms_now() * JOINTS;
            for (int s = 0; s < n; s++) begin
              filt[s] = pvel[s];
              queue_result(1'(s / JOINTS), 3'(s % JOINTS), peff[s][31:0], 1'b1,
                           jhpd_pkg::STATUS_OK, s == n - 1);
            end
            zero_req = 1'b1;
          end else begin
            st = active ? jhpd_pkg::STATUS_FAULT : jhpd_pkg::STATUS_INACTIVE;
            faulted = 1'b0;
            if (zero_req) begin
              queue_zero_burst(st);
              zero_req = 1'b0;
            end else begin
              queue_result(1'b0, 3'd0, 32'd0, 1'b0, st, 1'b1);
            end
          end
        end
      end
    endcase
  endfunction

  task flag_mismatch(string msg);
    errors++;
    $display("tb: mismatch: %s", msg);
  endtask

  // Compare one accepted result word with the oldest one due.
  task check_word(effort_word_t got);
    effort_word_t want;
    if (due_efforts.size() == 0) begin
      flag_mismatch($sformatf("unexpected word arm %0d joint %0d effort %h wv %0d st %0d",
                              got.arm, got.joint, got.effort, got.wv, got.st));
      return;
    end
    want = due_efforts.pop_front();
    if (got != want)
      flag_mismatch($sformatf(
        "got arm %0d joint %0d effort %h wv %0d st %0d last %0d, want %0d %0d %h %0d %0d %0d",
        got.arm, got.joint, got.effort, got.wv, got.st, got.last,
        want.arm, want.joint, want.effort, want.wv, want.st, want.last));
  endtask
endclass

module testbench;

  // longest run of cycles with no handshake on either stream
  localparam int STALL_LIMIT   = 2000;
  // cycles left for the block to finish a word that causes no result
  localparam int SETTLE_CYCLES = 30;
  localparam int RANDOM_WORDS  = 87;

  logic                             clk;
  logic                             rst_n;
  logic [jhpd_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic [jhpd_pkg::IN_TUSER_W-1:0]  in_tuser;
  logic                             in_tlast;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [jhpd_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [jhpd_pkg::OUT_TUSER_W-1:0] out_tuser;
  logic                             out_tlast;
  logic                             out_tvalid;
  logic                             out_tready;
  logic                             cfg_we;
  logic [jhpd_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [jhpd_pkg::CFG_DATA_W-1:0]  cfg_wdata;

  effort_predictor sb;
  int words_sent;
  int in_calm;
  int out_calm;
  int idle_cycles;

  joint_hold_pd_controller #(.JOINTS(JOINTS), .ARMS(ARMS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // end the run when neither stream moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // idle length for one word, with occasional stretches of no idling
  task automatic draw_gap(inout int calm, output int gap);
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 24) == 0) calm = $urandom_range(8, 30);
      gap = $urandom_range(0, 9);
    end
  endtask

  function automatic bit [31:0] spread(int r);
    return $urandom_range(0, 2 * r) - r;
  endfunction

  function automatic joint_word_t noise_word();
    joint_word_t w;
    w.cmd = 2'($urandom_range(0, 3));
    w.arm = 1'($urandom_range(0, 1));
    w.joint = 3'($urandom_range(0, 7));
    w.pos = $urandom;
    w.vel = $urandom;
    w.cor = $urandom;
    w.ok = 1'($urandom_range(0, 1));
    w.last = 1'($urandom_range(0, 1));
    w.k = $urandom;
    w.d = $urandom;
    w.lim = 23'($urandom);
    return w;
  endfunction

  function automatic joint_word_t plain_word(bit [1:0] cmd, bit arm, bit [2:0] joint,
                                             bit [31:0] pos, bit [31:0] vel,
                                             bit [31:0] cor, bit ok, bit last);
    joint_word_t w;
    w = '0;
    w.cmd = cmd;
    w.arm = arm;
    w.joint = joint;
    w.pos = pos;
    w.vel = vel;
    w.cor = cor;
    w.ok = ok;
    w.last = last;
    return w;
  endfunction

  // well-formed run sample close to the held position
  function automatic joint_word_t run_word(int slot);
    joint_word_t w;
    w = noise_word();
    w.cmd = jhpd_pkg::CMD_RUN;
    w.arm = 1'(slot / JOINTS);
    w.joint = 3'(slot % JOINTS);
    w.pos = sb.hold[slot][31:0] - spread(32'h10000);
    w.vel = spread(32'h40000);
    w.cor = spread(32'h40000);
    w.ok = 1'b1;
    return w;
  endfunction

  // break one word in one of the ways that can fault a cycle
  function automatic void disturb(inout joint_word_t w);
    case ($urandom_range(0, 3))
      0: w.ok = 1'b0;
      1: w.joint = 3'd7;
      2: w.arm = ~w.arm;
      default: w.pos = $urandom;
    endcase
  endfunction

  function automatic bit gains_wild(int s);
    return sb.kt[s] > 32'h20000 || sb.dt[s] > 32'h10000 || sb.lt[s] < 23'h100000;
  endfunction

  // Send one word and note it at its acceptance.
  task automatic send_word(joint_word_t w);
    int gap;
    if (sb.reads_unset(w)) w.ok = 1'b0;
    draw_gap(in_calm, gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= {5'd0, w.lim, w.d, w.k, w.cor, w.vel, w.pos, w.joint, w.arm};
    in_tuser <= {w.ok, w.cmd};
    in_tlast <= w.last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_word(w);
    words_sent++;
  endtask

  // Take result words with random stalls and check each one.
  task automatic take_results();
    int gap;
    effort_word_t got;
    forever begin
      draw_gap(out_calm, gap);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got.arm = out_tdata[0];
      got.joint = out_tdata[3:1];
      got.effort = out_tdata[35:4];
      got.wv = out_tuser[0];
      got.st = out_tuser[2:1];
      got.last = out_tlast;
      sb.check_word(got);
    end
  endtask

  // Hold the input idle until every due word has come, then let the block finish.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.due_efforts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_settings(bit [1:0] arms, bit [16:0] alpha);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= jhpd_pkg::REG_ARMS;
    cfg_wdata <= {15'd0, arms};
    @(posedge clk);
    cfg_index <= jhpd_pkg::REG_ALPHA;
    cfg_wdata <= alpha;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.arms_cfg = arms;
    sb.alpha_cfg = alpha;
  endtask

  task automatic directed_words();
    joint_word_t w;
    bit [31:0] cap_pos[JOINTS];
    bit [31:0] cap_vel[JOINTS];
    cap_pos = '{32'h0003_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                32'h0001_8000, 32'hFFFE_0000, 32'h0000_0001};
    cap_vel = '{32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                32'hFFFF_FFFF, 32'h0000_4000, 32'h0};
    // run while inactive gives an inactive status word
    send_word(plain_word(jhpd_pkg::CMD_RUN, 1'b0, 3'd0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1));
    // loads, among them a closing one and one out of range; none answers
    w = plain_word(jhpd_pkg::CMD_LOAD, 1'b0, 3'd0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1);
    w.k = 32'h0001_0000;
    w.d = 32'h0000_8000;
    w.lim = 23'h7FFFFF;
    send_word(w);
    w = plain_word(jhpd_pkg::CMD_LOAD, 1'b1, 3'd6, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
    w.k = 32'hFFFF_FFFF;
    w.d = 32'hFFFF_FFFF;
    send_word(w);
    w = noise_word();
    w.cmd = jhpd_pkg::CMD_LOAD;
    w.joint = 3'd7;
    send_word(w);
    send_word(plain_word(jhpd_pkg::CMD_DEACT, 1'b0, 3'd0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1));
    // capture every joint of arm 0 at extreme positions and velocities
    for (int j = 0; j < JOINTS; j++)
      send_word(plain_word(jhpd_pkg::CMD_CAPTURE, 1'b0, 3'(j), cap_pos[j], cap_vel[j],
                           32'h0, 1'b1, j == JOINTS - 1));
    // clean run cycle, then one that skips all but one joint
    for (int j = 0; j < JOINTS; j++)
      send_word(plain_word(jhpd_pkg::CMD_RUN, 1'b0, 3'(j),
                           (j == 0) ? 32'h0002_0000 : cap_pos[j],
                           (j == 0) ? 32'h0002_0000 : cap_vel[j],
                           (j == 0) ? 32'h0000_8000 : 32'h0, 1'b1, j == JOINTS - 1));
    send_word(plain_word(jhpd_pkg::CMD_RUN, 1'b0, 3'd3, 32'h0, 32'hFFFF_0000, 32'h0,
                         1'b1, 1'b1));
    // joint out of range, then an arm not in use
    send_word(plain_word(jhpd_pkg::CMD_RUN, 1'b0, 3'd7, 32'h0, 32'h0, 32'h8000_0000,
                         1'b1, 1'b1));
    send_word(plain_word(jhpd_pkg::CMD_RUN, 1'b1, 3'd0, 32'h0, 32'h0, 32'h7FFF_FFFF,
                         1'b1, 1'b1));
    // capture then a bad run closing the same cycle
    send_word(plain_word(jhpd_pkg::CMD_CAPTURE, 1'b0, 3'd0, 32'h0003_0000, 32'h0, 32'h0,
                         1'b1, 1'b0));
    send_word(plain_word(jhpd_pkg::CMD_RUN, 1'b0, 3'd0, 32'h0003_0000, 32'h0, 32'h0,
                         1'b0, 1'b1));
    // faulted capture close deactivates, and the next run finds it inactive
    send_word(plain_word(jhpd_pkg::CMD_CAPTURE, 1'b0, 3'd1, 32'h0, 32'h0, 32'h0,
                         1'b0, 1'b1));
    send_word(plain_word(jhpd_pkg::CMD_RUN, 1'b0, 3'd0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1));
  endtask

  task automatic run_cycle();
    int slots[$];
    int n;
    joint_word_t w;
    n = sb.arms_now() * JOINTS;
    for (int s = 0; s < n; s++)
      if ($urandom_range(0, 9) != 0) slots = {slots, s};
    if (slots.size() == 0) slots = {slots, int'($urandom_range(0, n - 1))};
    foreach (slots[i]) begin
      w = run_word(slots[i]);
      if ($urandom_range(0, 39) == 0) disturb(w);
      w.last = (i == slots.size() - 1);
      // now and then close a run cycle with a capture
      if (w.last && $urandom_range(0, 19) == 0) w.cmd = jhpd_pkg::CMD_CAPTURE;
      send_word(w);
    end
  endtask

  task automatic capture_cycle();
    int n;
    joint_word_t w;
    n = sb.arms_now() * JOINTS;
    for (int s = 0; s < n; s++) begin
      w = noise_word();
      w.cmd = jhpd_pkg::CMD_CAPTURE;
      w.arm = 1'(s / JOINTS);
      w.joint = 3'(s % JOINTS);
      w.pos = spread(32'h40_0000);
      w.vel = spread(32'h4_0000);
      w.ok = 1'b1;
      if ($urandom_range(0, 39) == 0) disturb(w);
      w.last = (s == n - 1);
      if (!w.last && $urandom_range(0, 19) == 0) w.cmd = jhpd_pkg::CMD_RUN;
      send_word(w);
    end
  endtask

  // reload gains, favouring slots with large gains or a low effort limit
  task automatic load_burst();
    int wild[$];
    int s;
    joint_word_t w;
    repeat ($urandom_range(1, 3)) begin
      wild.delete();
      for (int i = 0; i < SLOTS; i++)
        if (gains_wild(i)) wild = {wild, i};
      w = noise_word();
      w.cmd = jhpd_pkg::CMD_LOAD;
      if (wild.size() != 0 && $urandom_range(0, 9) < 7) begin
        s = wild[$urandom_range(0, wild.size() - 1)];
        w.arm = 1'(s / JOINTS);
        w.joint = 3'(s % JOINTS);
      end
      if ($urandom_range(0, 99) >= 15) begin
        w.k = $urandom_range(0, 32'h2_0000);
        w.d = $urandom_range(0, 32'h1_0000);
        w.lim = 23'($urandom_range(23'h10_0000, 23'h57_0000));
      end
      send_word(w);
    end
  endtask

  task automatic random_phase(int count);
    int start;
    int pick;
    joint_word_t w;
    start = words_sent;
    while (words_sent - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        run_cycle();
      end else if (pick < 70) begin
        capture_cycle();
      end else if (pick < 85) begin
        load_burst();
      end else if (pick < 90) begin
        w = noise_word();
        w.cmd = jhpd_pkg::CMD_DEACT;
        send_word(w);
      end else begin
        send_word(noise_word());
      end
    end
  endtask

  initial begin
    sb = new();
    words_sent = 0;
    in_calm = 0;
    out_calm = 0;
    rst_n = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    in_tlast = 1'b0;
    in_tvalid = 1'b0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = jhpd_pkg::REG_ARMS;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    write_settings(2'd1, 17'd65536);
    directed_words();

    settle();
    write_settings(2'd2, 17'd0);
    random_phase(RANDOM_WORDS);
    settle();
    write_settings(2'd0, 17'h1FFFF);
    random_phase(RANDOM_WORDS);
    settle();
    write_settings(2'd3, 17'($urandom_range(1, 65535)));
    random_phase(RANDOM_WORDS);
    settle();
    write_settings(2'd2, 17'd6554);
    random_phase(RANDOM_WORDS);

    settle();
    if (sb.due_efforts.size() != 0)
      sb.flag_mismatch($sformatf("%0d result words never arrived", sb.due_efforts.size()));
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    wait (rst_n === 1'b1);
    take_results();
  end

endmodule
